### sv/rmt_pkg.sv
// Shared types and constants for the region map table.
package rmt_pkg;

   localparam logic [31:0] WINDOW_LOW_RESET  = 32'h6000_0000;
   localparam logic [31:0] WINDOW_HIGH_RESET = 32'h8000_0000;
   localparam logic [19:0] LOADED_MAX        = 20'hF_FFFF;

   typedef enum logic [1:0] {
      ACT_MAP_FIXED = 2'd0,
      ACT_MAP_ANY   = 2'd1,
      ACT_UNMAP     = 2'd2,
      ACT_FAULT     = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      STS_OK             = 4'd0,
      STS_ZERO_LENGTH    = 4'd1,
      STS_SHARED_PRIVATE = 4'd2,
      STS_BAD_ADDR       = 4'd3,
      STS_OVERLAP        = 4'd4,
      STS_TABLE_FULL     = 4'd5,
      STS_NO_SPACE       = 4'd6,
      STS_BAD_HANDLE     = 4'd7,
      STS_NOT_FOUND      = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRECHECK,
      S_READ,
      S_CHECK,
      S_PASS_END,
      S_COMMIT,
      S_DONE
   } state_type;

   localparam logic [0:0] CSR_WINDOW_LOW  = 1'b0;
   localparam logic [0:0] CSR_WINDOW_HIGH = 1'b1;

   typedef struct packed {
      logic [31:0] base;
      logic [30:0] length;
      logic [19:0] loaded;
      logic        anonymous;
      logic        shared;
      logic [3:0]  handle;
   } entry_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] result_addr;
      logic [3:0]  entry_index;
      logic [30:0] region_length;
      logic        entry_anonymous;
      logic        entry_shared;
      logic [3:0]  entry_handle;
      logic [30:0] file_offset;
      logic [4:0]  maps_in_use;
      logic [19:0] loaded_pages;
   } result_type;

   typedef struct packed {
      logic       req_ready;
      logic       load_req;
      logic       start_pass;
      logic       scan_step;
      logic       advance;
      logic       status_we;
      status_type status_code;
      logic       commit;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_valid;
      action_type action;
      status_type early;
      logic       conf_seen;
      logic       hit_seen;
      logic       handle_bad;
      logic       last_slot;
      logic       rsp_free;
   } dp_stat_type;

endpackage

### sv/rmt_ifs.sv
// Request and response channel interfaces for the region map table.
interface rmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] addr;
   logic [30:0] length;
   logic        flag_anonymous;
   logic        flag_shared;
   logic        flag_private;
   logic [3:0]  file_handle;

   modport source (output valid, action, addr, length, flag_anonymous, flag_shared,
                   flag_private, file_handle, input ready);
   modport sink (input valid, action, addr, length, flag_anonymous, flag_shared,
                 flag_private, file_handle, output ready);
endinterface

interface rmt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [31:0] result_addr;
   logic [3:0]  entry_index;
   logic [30:0] region_length;
   logic        entry_anonymous;
   logic        entry_shared;
   logic [3:0]  entry_handle;
   logic [30:0] file_offset;
   logic [4:0]  maps_in_use;
   logic [19:0] loaded_pages;

   modport source (output valid, status, result_addr, entry_index, region_length,
                   entry_anonymous, entry_shared, entry_handle, file_offset,
                   maps_in_use, loaded_pages, input ready);
   modport sink (input valid, status, result_addr, entry_index, region_length,
                 entry_anonymous, entry_shared, entry_handle, file_offset,
                 maps_in_use, loaded_pages, output ready);
endinterface

### sv/rmt_ctrl.sv
// Sequencer for the region map table: request intake, slot scans, commit, response.
module rmt_ctrl
   import rmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (stat.req_valid) state_in = S_PRECHECK;
         end
         S_PRECHECK: begin
            state_in = (stat.early != STS_OK) ? S_COMMIT : S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.last_slot ? S_PASS_END : S_READ;
         end
         S_PASS_END: begin
            // a conflict in the open search moves the candidate and rescans
            if (stat.action == ACT_MAP_ANY && stat.conf_seen) state_in = S_PRECHECK;
            else state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status_code = STS_OK;
      unique case (state_ff)
         S_IDLE: begin
            // hold off requests while reset is applied
            cmd.req_ready = !reset;
            cmd.load_req  = stat.req_valid && !reset;
         end
         S_PRECHECK: begin
            if (stat.early != STS_OK) begin
               cmd.status_we   = 1'b1;
               cmd.status_code = stat.early;
            end else begin
               cmd.start_pass = 1'b1;
            end
         end
         S_READ: begin
         end
         S_CHECK: begin
            cmd.scan_step = 1'b1;
         end
         S_PASS_END: begin
            unique case (stat.action)
               ACT_MAP_FIXED: begin
                  cmd.status_we = 1'b1;
                  if (stat.conf_seen) cmd.status_code = STS_OVERLAP;
                  else if (stat.handle_bad) cmd.status_code = STS_BAD_HANDLE;
                  else cmd.status_code = STS_OK;
               end
               ACT_MAP_ANY: begin
                  if (stat.conf_seen) begin
                     cmd.advance = 1'b1;
                  end else begin
                     cmd.status_we   = 1'b1;
                     cmd.status_code = stat.handle_bad ? STS_BAD_HANDLE : STS_OK;
                  end
               end
               ACT_UNMAP, ACT_FAULT: begin
                  cmd.status_we   = 1'b1;
                  cmd.status_code = stat.hit_seen ? STS_OK : STS_NOT_FOUND;
               end
               default: begin
               end
            endcase
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### sv/rmt_dpath.sv
// Datapath for the region map table: slot store, scan compare, window registers, result.
module rmt_dpath
   import rmt_pkg::*;
#(
   parameter int TABLE_SLOTS  = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int HANDLE_COUNT = 16
)(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic         csr_wr_en,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_wr_data,
   rmt_req_if.sink      req_ch,
   rmt_rsp_if.source    rsp_ch
);

   localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
   localparam int COUNT_BITS = $clog2(TABLE_SLOTS + 1);
   localparam logic [33:0] PAGE_MASK34 = 34'(PAGE_BYTES - 1);
   localparam logic [31:0] PAGE_MASK32 = 32'(PAGE_BYTES - 1);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

   // request
   action_type  act_ff;
   logic [31:0] addr_ff;
   logic [30:0] len_ff;
   logic        anon_ff, shared_ff, priv_ff;
   logic [3:0]  handle_ff;

   logic [31:0] wlow_ff, whigh_ff;
   logic [33:0] cand_ff;

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SLOT_BITS-1:0]   scan_ff;

   entry_type mem [TABLE_SLOTS];
   entry_type rd_ff;

   logic                 conf_seen_ff, free_seen_ff, hit_seen_ff;
   logic [33:0]          conf_top_ff;
   logic [SLOT_BITS-1:0] free_ff, hit_idx_ff;
   entry_type            hit_ff;
   status_type           status_ff;

   result_type res_ff, res_in, out_ff;
   logic       rsp_valid_ff;

   // slot compare
   logic        slot_valid;
   logic [32:0] top33;
   logic [33:0] top_up, cand_end;
   logic [31:0] page_addr;
   logic        overlap, unmap_match, fault_match, match;
   logic        fits, bad_addr, handle_bad;
   status_type  early;

   // commit
   logic                 ok, wr_en;
   logic [SLOT_BITS-1:0] wr_idx;
   entry_type            wr_data;
   logic [19:0]          loaded_next;
   logic [30:0]          offset;

   assign slot_valid  = valid_ff[scan_ff];
   assign top33       = {1'b0, rd_ff.base} + {2'b0, rd_ff.length};
   assign top_up      = ({1'b0, top33} + PAGE_MASK34) & ~PAGE_MASK34;
   assign cand_end    = cand_ff + {3'b0, len_ff};
   assign page_addr   = addr_ff & ~PAGE_MASK32;
   assign overlap     = slot_valid && (cand_ff < {1'b0, top33}) &&
                        ({2'b0, rd_ff.base} < cand_end);
   assign unmap_match = slot_valid && (rd_ff.base == page_addr);
   assign fault_match = slot_valid && (addr_ff >= rd_ff.base) && ({1'b0, addr_ff} < top33);
   assign match       = (act_ff == ACT_UNMAP) ? unmap_match : fault_match;

   assign fits       = ({1'b0, cand_ff} + {4'b0, len_ff}) < {3'b0, whigh_ff};
   assign bad_addr   = (addr_ff < wlow_ff) || (addr_ff >= whigh_ff) ||
                       ((addr_ff & PAGE_MASK32) != 32'd0);
   assign handle_bad = !anon_ff &&
                       ((handle_ff == 4'd0) || ({28'b0, handle_ff} >= 32'(HANDLE_COUNT)));

   always_comb begin
      early = STS_OK;
      if (act_ff == ACT_MAP_FIXED || act_ff == ACT_MAP_ANY) begin
         priority if (len_ff == 31'd0) early = STS_ZERO_LENGTH;
         else if (shared_ff && priv_ff) early = STS_SHARED_PRIVATE;
         else if (count_ff >= COUNT_BITS'(TABLE_SLOTS)) early = STS_TABLE_FULL;
         else if (act_ff == ACT_MAP_FIXED && bad_addr) early = STS_BAD_ADDR;
         else if (act_ff == ACT_MAP_ANY && !fits) early = STS_NO_SPACE;
         else early = STS_OK;
      end
   end

   assign stat.req_valid  = req_ch.valid;
   assign stat.action     = act_ff;
   assign stat.early      = early;
   assign stat.conf_seen  = conf_seen_ff;
   assign stat.hit_seen   = hit_seen_ff;
   assign stat.handle_bad = handle_bad;
   assign stat.last_slot  = (scan_ff == LAST_SLOT);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = cmd.req_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff    <= action_type'(req_ch.action);
         addr_ff   <= req_ch.addr;
         len_ff    <= req_ch.length;
         anon_ff   <= req_ch.flag_anonymous;
         shared_ff <= req_ch.flag_shared;
         priv_ff   <= req_ch.flag_private;
         handle_ff <= req_ch.file_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlow_ff  <= WINDOW_LOW_RESET;
         whigh_ff <= WINDOW_HIGH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LOW:  wlow_ff  <= csr_wr_data;
            CSR_WINDOW_HIGH: whigh_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // fixed maps test the requested base, open maps start at the window floor
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         if (action_type'(req_ch.action) == ACT_MAP_FIXED) cand_ff <= {2'b0, req_ch.addr};
         else cand_ff <= {2'b0, wlow_ff};
      end else if (cmd.advance) begin
         cand_ff <= conf_top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pass) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end

   // keep the first conflict, free slot and hit of the pass
   always_ff @(posedge clock) begin
      if (reset) begin
         conf_seen_ff <= 1'b0;
         free_seen_ff <= 1'b0;
         hit_seen_ff  <= 1'b0;
      end else if (cmd.start_pass) begin
         conf_seen_ff <= 1'b0;
         free_seen_ff <= 1'b0;
         hit_seen_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         if (!conf_seen_ff && overlap) conf_seen_ff <= 1'b1;
         if (!free_seen_ff && !slot_valid) free_seen_ff <= 1'b1;
         if (!hit_seen_ff && match) hit_seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         if (!conf_seen_ff && overlap) conf_top_ff <= top_up;
         if (!free_seen_ff && !slot_valid) free_ff <= scan_ff;
         if (!hit_seen_ff && match) begin
            hit_idx_ff <= scan_ff;
            hit_ff     <= rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.status_we) status_ff <= cmd.status_code;
   end

   assign ok          = (status_ff == STS_OK);
   assign loaded_next = (hit_ff.loaded < LOADED_MAX) ? hit_ff.loaded + 20'd1 : hit_ff.loaded;
   assign offset      = (page_addr >= hit_ff.base) ? 31'(page_addr - hit_ff.base) : 31'd0;

   always_comb begin
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_idx   = free_ff;
      wr_data  = hit_ff;
      res_in   = '0;
      if (ok) begin
         unique case (act_ff)
            ACT_MAP_FIXED, ACT_MAP_ANY: begin
               count_in          = count_ff + 1'b1;
               wr_en             = 1'b1;
               wr_idx            = free_ff;
               wr_data.base      = cand_ff[31:0];
               wr_data.length    = len_ff;
               wr_data.loaded    = 20'd0;
               wr_data.anonymous = anon_ff;
               wr_data.shared    = shared_ff;
               wr_data.handle    = handle_ff;
               res_in.result_addr     = cand_ff[31:0];
               res_in.entry_index     = 4'(free_ff);
               res_in.region_length   = len_ff;
               res_in.entry_anonymous = anon_ff;
               res_in.entry_shared    = shared_ff;
               res_in.entry_handle    = handle_ff;
            end
            ACT_UNMAP: begin
               count_in = count_ff - 1'b1;
               res_in.result_addr     = hit_ff.base;
               res_in.entry_index     = 4'(hit_idx_ff);
               res_in.region_length   = hit_ff.length;
               res_in.entry_anonymous = hit_ff.anonymous;
               res_in.entry_shared    = hit_ff.shared;
               res_in.entry_handle    = hit_ff.handle;
               res_in.loaded_pages    = hit_ff.loaded;
            end
            ACT_FAULT: begin
               wr_en          = 1'b1;
               wr_idx         = hit_idx_ff;
               wr_data.loaded = loaded_next;
               res_in.result_addr     = page_addr;
               res_in.entry_index     = 4'(hit_idx_ff);
               res_in.region_length   = hit_ff.length;
               res_in.entry_anonymous = hit_ff.anonymous;
               res_in.entry_shared    = hit_ff.shared;
               res_in.entry_handle    = hit_ff.handle;
               res_in.file_offset     = offset;
               res_in.loaded_pages    = loaded_next;
            end
            default: begin
            end
         endcase
      end
      res_in.status      = status_ff;
      res_in.maps_in_use = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         if (ok) begin
            unique case (act_ff)
               ACT_MAP_FIXED, ACT_MAP_ANY: valid_ff[free_ff]    <= 1'b1;
               ACT_UNMAP:                  valid_ff[hit_idx_ff] <= 1'b0;
               ACT_FAULT: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) mem[wr_idx] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[scan_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) res_ff <= res_in;
      if (cmd.load_rsp) out_ff <= res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = out_ff.status;
   assign rsp_ch.result_addr     = out_ff.result_addr;
   assign rsp_ch.entry_index     = out_ff.entry_index;
   assign rsp_ch.region_length   = out_ff.region_length;
   assign rsp_ch.entry_anonymous = out_ff.entry_anonymous;
   assign rsp_ch.entry_shared    = out_ff.entry_shared;
   assign rsp_ch.entry_handle    = out_ff.entry_handle;
   assign rsp_ch.file_offset     = out_ff.file_offset;
   assign rsp_ch.maps_in_use     = out_ff.maps_in_use;
   assign rsp_ch.loaded_pages    = out_ff.loaded_pages;

endmodule

### sv/region_map_table_top.sv
// Top level of the region map table: sequencer plus datapath.
//
//   port      dir   kind              contents
//   req_ch    in    valid/ready       action, addr, length, flags, file_handle
//   rsp_ch    out   valid/ready       status, addresses, entry fields, counts
//   csr_*     in    write enable      index 0 window_low, index 1 window_high
//
// Each slot scan reads the slot store one entry at a time, through a read state and a
// check state per slot; fixed map, unmap and fault run at most one pass over all slots.
// Map-anywhere runs a further pass for each region it steps past.
// Synchronous reset clears the valid bits and the map count and loads the window reset values; no sweep.
// A waiting response is held in its output register while the next request runs.
module region_map_table_top
   import rmt_pkg::*;
#(
   parameter int TABLE_SLOTS  = 16,
   parameter int PAGE_BYTES   = 4096,
   parameter int HANDLE_COUNT = 16
)(
   input  logic        clock,
   input  logic        reset,
   rmt_req_if.sink     req_ch,
   rmt_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   rmt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   rmt_dpath #(
      .TABLE_SLOTS  (TABLE_SLOTS),
      .PAGE_BYTES   (PAGE_BYTES),
      .HANDLE_COUNT (HANDLE_COUNT)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

endmodule
